// File: src/look_at_view_matrix_macros.svh
// Assertion helpers used by the look-at view matrix RTL.
// Every use expects clk_i and rst_ni in scope.
`ifndef LOOK_AT_VIEW_MATRIX_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LAV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LAV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/lav_pkg.sv
package lav_pkg;

  // Default number of fraction bits.
  localparam int FRAC_BITS_DEF = 16;

  // The largest normalized magnitude lies in [2^29, 2^30).
  localparam int NORM_BITS = 30;
  // Square root of a sum of three such squares fits in 31 bits.
  localparam int LEN_BITS  = 31;
  // Working width of the square root unit.
  localparam int SQ_BITS   = 64;

  // Square root: 32 digit steps, two per stage.
  localparam int ISQ_PER    = 2;
  localparam int ISQ_STAGES = 16;

  // Latency of the cross product and translation units.
  localparam int CROSS_LAT  = 2;
  localparam int XLATE_LAT  = 3;

  // Latency of one normalize unit: front end, square root, divider, sign.
  function automatic int norm_lat(input int fb);
    return 7 + ISQ_STAGES + ((fb + 2) >> 1);
  endfunction

endpackage

// File: src/lav_dly.sv
module lav_dly #(
  parameter int W = 32,
  parameter int D = 3
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [D];

  // Shift line that moves only when the pipeline advances.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int k = 1; k < D; k++) begin
        sr_q[k] <= sr_q[k-1];
      end
    end
  end

  assign q_o = sr_q[D-1];

endmodule

// File: src/lav_norm.sv
module lav_norm
  import lav_pkg::*;
#(
  parameter int VW = 33,
  parameter int FB = FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [2:0][VW-1:0]  v_i,
  output logic [2:0][FB+1:0]  o_o
);

  localparam int PW   = $clog2(VW);
  localparam int QW   = 2 * ((FB + 2) / 2);
  localparam int DST  = QW / 2;
  localparam int RW   = LEN_BITS + QW + 1;
  localparam int NUMW = NORM_BITS + FB + 1;
  localparam int SQW  = 2 * NORM_BITS;

  // Stage 1: magnitudes, signs and the largest magnitude.
  logic [2:0][VW-1:0] mag_d, mag1_q, mag2_q;
  logic [VW-1:0]      max_d, max1_q;
  logic [2:0]         neg1_q, neg2_q, neg3_q, neg4_q;

  always_comb begin
    max_d = '0;
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = v_i[i][VW-1] ? (~v_i[i] + VW'(1)) : v_i[i];
      if (mag_d[i] > max_d) begin
        max_d = mag_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q <= mag_d;
      max1_q <= max_d;
      for (int i = 0; i < 3; i++) begin
        neg1_q[i] <= v_i[i][VW-1];
      end
    end
  end

  // Stage 2: position of the leading one of the largest magnitude.
  logic [PW-1:0] pos_d, pos2_q;
  logic          zero2_q, zero3_q, zero4_q;

  always_comb begin
    pos_d = '0;
    for (int b = 0; b < VW; b++) begin
      if (max1_q[b]) begin
        pos_d = PW'(b);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag2_q  <= mag1_q;
      neg2_q  <= neg1_q;
      pos2_q  <= pos_d;
      zero2_q <= (max1_q == '0);
    end
  end

  // Stage 3: common shift that brings the largest into [2^29, 2^30).
  logic [2:0][NORM_BITS-1:0] sm_d, sm3_q, sm4_q;

  always_comb begin
    logic [VW-1:0] sh;
    for (int i = 0; i < 3; i++) begin
      if (pos2_q >= PW'(NORM_BITS - 1)) begin
        sh = mag2_q[i] >> (pos2_q - PW'(NORM_BITS - 1));
      end else begin
        sh = mag2_q[i] << (PW'(NORM_BITS - 1) - pos2_q);
      end
      sm_d[i] = sh[NORM_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sm3_q   <= sm_d;
      neg3_q  <= neg2_q;
      zero3_q <= zero2_q;
    end
  end

  // Stage 4: squares.
  logic [2:0][SQW-1:0] sq4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq4_q[i] <= SQW'(sm3_q[i]) * SQW'(sm3_q[i]);
      end
      sm4_q   <= sm3_q;
      neg4_q  <= neg3_q;
      zero4_q <= zero3_q;
    end
  end

  // Stage 5: sum of squares enters the square root pipeline.
  logic [SQ_BITS-1:0]        n_q   [ISQ_STAGES];
  logic [SQ_BITS-1:0]        r_q   [ISQ_STAGES+1];
  logic [2:0][NORM_BITS-1:0] ism_q [ISQ_STAGES+1];
  logic [2:0]                ineg_q[ISQ_STAGES+1];
  logic                      izro_q[ISQ_STAGES+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]    <= SQ_BITS'(sq4_q[0]) + SQ_BITS'(sq4_q[1]) + SQ_BITS'(sq4_q[2]);
      r_q[0]    <= '0;
      ism_q[0]  <= sm4_q;
      ineg_q[0] <= neg4_q;
      izro_q[0] <= zero4_q;
    end
  end

  // Square root, two digit steps per stage.
  for (genvar s = 0; s < ISQ_STAGES; s++) begin : g_isq
    logic [SQ_BITS-1:0] n_c, r_c;

    always_comb begin
      logic [SQ_BITS-1:0] b;
      n_c = n_q[s];
      r_c = r_q[s];
      for (int k = 0; k < ISQ_PER; k++) begin
        b = SQ_BITS'(1) << (SQ_BITS - 2 - 2 * (s * ISQ_PER + k));
        if (n_c >= r_c + b) begin
          n_c = n_c - (r_c + b);
          r_c = (r_c >> 1) + b;
        end else begin
          r_c = r_c >> 1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s+1]    <= r_c;
        ism_q[s+1]  <= ism_q[s];
        ineg_q[s+1] <= ineg_q[s];
        izro_q[s+1] <= izro_q[s];
      end
    end

    if (s < ISQ_STAGES - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          n_q[s+1] <= n_c;
        end
      end
    end
  end

  // Divider setup: numerator with half the length added for rounding.
  logic [LEN_BITS-1:0]  len;
  logic [2:0][RW-1:0]   rem_q [DST];
  logic [2:0][QW-1:0]   q_q   [DST+1];
  logic [LEN_BITS-1:0]  dv_q  [DST];
  logic [2:0]           dneg_q[DST+1];
  logic                 dzro_q[DST+1];

  assign len = r_q[ISQ_STAGES][LEN_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[0][i] <= RW'((NUMW'(ism_q[ISQ_STAGES][i]) << FB) + NUMW'(len >> 1));
      end
      q_q[0]    <= '0;
      dv_q[0]   <= len;
      dneg_q[0] <= ineg_q[ISQ_STAGES];
      dzro_q[0] <= izro_q[ISQ_STAGES];
    end
  end

  // Restoring division, two quotient bits per stage.
  for (genvar s = 0; s < DST; s++) begin : g_div
    logic [2:0][RW-1:0] rem_c;
    logic [2:0][QW-1:0] q_c;

    always_comb begin
      logic [RW-1:0] sub;
      for (int i = 0; i < 3; i++) begin
        rem_c[i] = rem_q[s][i];
        q_c[i]   = q_q[s][i];
        for (int k = 0; k < 2; k++) begin
          sub = RW'(dv_q[s]) << (QW - 1 - 2 * s - k);
          if (rem_c[i] >= sub) begin
            rem_c[i] = rem_c[i] - sub;
            q_c[i]   = {q_c[i][QW-2:0], 1'b1};
          end else begin
            q_c[i]   = {q_c[i][QW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[s+1]    <= q_c;
        dneg_q[s+1] <= dneg_q[s];
        dzro_q[s+1] <= dzro_q[s];
      end
    end

    if (s < DST - 1) begin : g_pass
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s+1] <= rem_c;
          dv_q[s+1]  <= dv_q[s];
        end
      end
    end
  end

  // Final stage: restore signs; a zero vector gives zero.
  logic [2:0][FB+1:0] o_d, o_q;

  always_comb begin
    logic [FB+1:0] qv;
    for (int i = 0; i < 3; i++) begin
      qv = {1'b0, q_q[DST][i][FB:0]};
      if (dzro_q[DST]) begin
        o_d[i] = '0;
      end else if (dneg_q[DST][i]) begin
        o_d[i] = -qv;
      end else begin
        o_d[i] = qv;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o_q <= o_d;
    end
  end

  assign o_o = o_q;

endmodule

// File: src/lav_cross.sv
module lav_cross #(
  parameter int AW = 18,
  parameter int BW = 32
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [2:0][AW-1:0]     a_i,
  input  logic [2:0][BW-1:0]     b_i,
  output logic [2:0][AW+BW:0]    c_o
);

  localparam int PW = AW + BW;

  logic signed [PW-1:0] p_d [6];
  logic signed [PW-1:0] p_q [6];
  logic [2:0][PW:0]     c_q;

  // Stage 1: the six partial products.
  always_comb begin
    p_d[0] = $signed(a_i[1]) * $signed(b_i[2]);
    p_d[1] = $signed(a_i[2]) * $signed(b_i[1]);
    p_d[2] = $signed(a_i[2]) * $signed(b_i[0]);
    p_d[3] = $signed(a_i[0]) * $signed(b_i[2]);
    p_d[4] = $signed(a_i[0]) * $signed(b_i[1]);
    p_d[5] = $signed(a_i[1]) * $signed(b_i[0]);
  end

  // Stage 2: differences at full precision.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
      for (int i = 0; i < 3; i++) begin
        c_q[i] <= (PW+1)'(p_q[2*i]) - (PW+1)'(p_q[2*i+1]);
      end
    end
  end

  assign c_o = c_q;

endmodule

// File: src/lav_xlate.sv
module lav_xlate
  import lav_pkg::*;
#(
  parameter int FB = FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [2:0][FB+1:0]  r_i,
  input  logic [2:0][FB+1:0]  u_i,
  input  logic [2:0][FB+1:0]  f_i,
  input  logic [2:0][31:0]    eye_i,
  output logic [2:0][31:0]    t_o
);

  localparam int PW = FB + 34;
  localparam int SW = FB + 36;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FB - 1);

  logic [2:0][FB+1:0]        ax [3];
  logic signed [PW-1:0]      p_q [3][3];
  logic signed [SW-1:0]      s_q [3];
  logic [2:0][31:0]          t_q;

  assign ax[0] = r_i;
  assign ax[1] = u_i;
  assign ax[2] = f_i;

  // Stages 1 and 2: products with the eye point, then the dot sums.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int v = 0; v < 3; v++) begin
        for (int i = 0; i < 3; i++) begin
          p_q[v][i] <= $signed(ax[v][i]) * $signed(eye_i[i]);
        end
        s_q[v] <= SW'(p_q[v][0]) + SW'(p_q[v][1]) + SW'(p_q[v][2]);
      end
    end
  end

  // Stage 3: rescale rounding half up, negate right and up terms, saturate.
  always_ff @(posedge clk_i) begin
    logic signed [SW-1:0] sc;
    logic signed [SW:0]   n;
    if (en_i) begin
      for (int v = 0; v < 3; v++) begin
        sc = (s_q[v] + HALF) >>> FB;
        n  = (v == 2) ? (SW+1)'(sc) : -((SW+1)'(sc));
        if ((n[SW:31] == '0) || (n[SW:31] == '1)) begin
          t_q[v] <= n[31:0];
        end else if (n[SW]) begin
          t_q[v] <= 32'h8000_0000;
        end else begin
          t_q[v] <= 32'h7FFF_FFFF;
        end
      end
    end
  end

  assign t_o = t_q;

endmodule

// File: src/look_at_view_matrix.sv
// Right-handed look-at view matrix in signed fixed point (Q16.16 by default).
// Input channel (in_valid_i / in_ready_o) carries one camera setup per item:
// eye point, target point and approximate up vector. Output channel
// (out_valid_o / out_ready_i) returns one item with the right axis, the true
// up axis, the negated forward axis and the three saturated translations.
// The datapath is a single stalling pipeline whose depth is set mostly by
// the two normalize units (a 16-stage square root and a radix-4 divider each).
// Throughput is one item per cycle as long as the receiver takes results.
// When out_valid_o is high and out_ready_i is low the whole pipeline holds
// and in_ready_o drops; nothing in flight is lost or repeated.
// Reset clears only the valid bits, so the block comes up empty and ready.
// A zero-length forward or right vector gives zeros in every dependent field.
module look_at_view_matrix
  import lav_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] eye_x_i,
  input  logic [31:0] eye_y_i,
  input  logic [31:0] eye_z_i,
  input  logic [31:0] target_x_i,
  input  logic [31:0] target_y_i,
  input  logic [31:0] target_z_i,
  input  logic [31:0] cam_up_x_i,
  input  logic [31:0] cam_up_y_i,
  input  logic [31:0] cam_up_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [17:0] right_x_o,
  output logic [17:0] right_y_o,
  output logic [17:0] right_z_o,
  output logic [17:0] true_up_x_o,
  output logic [17:0] true_up_y_o,
  output logic [17:0] true_up_z_o,
  output logic [17:0] back_x_o,
  output logic [17:0] back_y_o,
  output logic [17:0] back_z_o,
  output logic [31:0] shift_right_o,
  output logic [31:0] shift_up_o,
  output logic [31:0] shift_forward_o
);

  localparam int AXW = FRAC_BITS + 2;
  localparam int C1W = AXW + 33;
  localparam int C2W = 2 * AXW + 1;
  localparam int L1  = norm_lat(FRAC_BITS);
  localparam int F   = 1 + L1;
  localparam int R   = F + CROSS_LAT + L1;
  localparam int L   = R + 1 + CROSS_LAT + XLATE_LAT;

  localparam logic signed [C2W-1:0] HALF = C2W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [C2W-1:0] ONE  = C2W'(1) <<< FRAC_BITS;

  logic         en;
  logic [L-1:0] vld_q;

  // Valid bits travel with the data; everything advances together.
  assign en          = !vld_q[L-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[L-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[L-2:0], in_valid_i};
    end
  end

  logic [2:0][31:0] eye_in, tgt_in, up_in, eye_d, up_d;

  assign eye_in = {eye_z_i, eye_y_i, eye_x_i};
  assign tgt_in = {target_z_i, target_y_i, target_x_i};
  assign up_in  = {cam_up_z_i, cam_up_y_i, cam_up_x_i};

  // Forward difference, one bit wider than the inputs.
  logic [2:0][32:0] dif_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dif_q[i] <= $signed({tgt_in[i][31], tgt_in[i]}) - $signed({eye_in[i][31], eye_in[i]});
      end
    end
  end

  // Forward axis.
  logic [2:0][AXW-1:0] f_w, f_a, f_b, f_c;

  lav_norm #(.VW(33), .FB(FRAC_BITS)) u_norm_f (
    .clk_i (clk_i),
    .en_i  (en),
    .v_i   (dif_q),
    .o_o   (f_w)
  );

  lav_dly #(.W(96), .D(F)) u_dly_up (
    .clk_i (clk_i), .en_i (en), .d_i (up_in), .q_o (up_d)
  );

  // Unnormalized right axis: forward cross up.
  logic [2:0][C1W-1:0] c1_w;

  lav_cross #(.AW(AXW), .BW(32)) u_cross_fu (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (f_w),
    .b_i   (up_d),
    .c_o   (c1_w)
  );

  // Right axis.
  logic [2:0][AXW-1:0] r_w, r_b, r_c;

  lav_norm #(.VW(C1W), .FB(FRAC_BITS)) u_norm_r (
    .clk_i (clk_i),
    .en_i  (en),
    .v_i   (c1_w),
    .o_o   (r_w)
  );

  lav_dly #(.W(3*AXW), .D(L1 + CROSS_LAT)) u_dly_fa (
    .clk_i (clk_i), .en_i (en), .d_i (f_w), .q_o (f_a)
  );

  // True up: right cross forward, rescaled and clamped.
  logic [2:0][C2W-1:0] c2_w;
  logic [2:0][AXW-1:0] u_q, u_c;

  lav_cross #(.AW(AXW), .BW(AXW)) u_cross_rf (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (r_w),
    .b_i   (f_a),
    .c_o   (c2_w)
  );

  always_ff @(posedge clk_i) begin
    logic signed [C2W-1:0] t;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t = ($signed(c2_w[i]) + HALF) >>> FRAC_BITS;
        if (t > ONE) begin
          t = ONE;
        end else if (t < -ONE) begin
          t = -ONE;
        end
        u_q[i] <= t[AXW-1:0];
      end
    end
  end

  lav_dly #(.W(3*AXW), .D(CROSS_LAT + 1)) u_dly_rb (
    .clk_i (clk_i), .en_i (en), .d_i (r_w), .q_o (r_b)
  );

  lav_dly #(.W(3*AXW), .D(CROSS_LAT + 1)) u_dly_fb (
    .clk_i (clk_i), .en_i (en), .d_i (f_a), .q_o (f_b)
  );

  lav_dly #(.W(96), .D(R + CROSS_LAT + 1)) u_dly_eye (
    .clk_i (clk_i), .en_i (en), .d_i (eye_in), .q_o (eye_d)
  );

  // Translations.
  logic [2:0][31:0] t_w;

  lav_xlate #(.FB(FRAC_BITS)) u_xlate (
    .clk_i (clk_i),
    .en_i  (en),
    .r_i   (r_b),
    .u_i   (u_q),
    .f_i   (f_b),
    .eye_i (eye_d),
    .t_o   (t_w)
  );

  // Axes wait for the translations.
  lav_dly #(.W(3*AXW), .D(XLATE_LAT)) u_dly_rc (
    .clk_i (clk_i), .en_i (en), .d_i (r_b), .q_o (r_c)
  );

  lav_dly #(.W(3*AXW), .D(XLATE_LAT)) u_dly_uc (
    .clk_i (clk_i), .en_i (en), .d_i (u_q), .q_o (u_c)
  );

  lav_dly #(.W(3*AXW), .D(XLATE_LAT)) u_dly_fc (
    .clk_i (clk_i), .en_i (en), .d_i (f_b), .q_o (f_c)
  );

  // Output fields.
  assign right_x_o       = 18'($signed(r_c[0]));
  assign right_y_o       = 18'($signed(r_c[1]));
  assign right_z_o       = 18'($signed(r_c[2]));
  assign true_up_x_o     = 18'($signed(u_c[0]));
  assign true_up_y_o     = 18'($signed(u_c[1]));
  assign true_up_z_o     = 18'($signed(u_c[2]));
  assign back_x_o        = 18'(-$signed(f_c[0]));
  assign back_y_o        = 18'(-$signed(f_c[1]));
  assign back_z_o        = 18'(-$signed(f_c[2]));
  assign shift_right_o   = t_w[0];
  assign shift_up_o      = t_w[1];
  assign shift_forward_o = t_w[2];

  `include "look_at_view_matrix_macros.svh"

  // A stall freezes every valid bit.
  `LAV_ASSERT_NXT(a_stall_holds, !en, $stable(vld_q), "valid bits moved during a stall")
  // A zero forward axis forces a zero right axis.
  `LAV_ASSERT_IMP(a_zero_right, vld_q[R-1] && (f_a == '0), r_w == '0, "right axis not zero")
  // A zero right axis forces a zero true up axis.
  `LAV_ASSERT_IMP(a_zero_up, vld_q[R+CROSS_LAT] && (r_b == '0), u_q == '0, "up axis not zero")
  // A zero forward axis gives no forward translation.
  `LAV_ASSERT_IMP(a_zero_fwd, out_valid_o && (f_c == '0), t_w[2] == '0, "forward shift not zero")

endmodule
